// ----- hw/rtl/fixed_step_time_accumulator_macros.svh -----
// assertion macros for the fixed step time accumulator
`ifndef FIXED_STEP_TIME_ACCUMULATOR_MACROS_SVH
`define FIXED_STEP_TIME_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FSTA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fixed_step_time_accumulator: same-cycle check failed");
`define FSTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fixed_step_time_accumulator: next-cycle check failed");
`else
`define FSTA_ASSERT_NOW(label, ante, cons)
`define FSTA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/fsta_pkg.sv -----
// shared types and constants of the fixed step time accumulator
package fsta_pkg;

  localparam int FRAME_W    = 32;
  localparam int CNT_W      = 8;
  localparam int OUT_W      = 32;
  localparam int LAG_W      = 48;
  localparam int STEP_SUM_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSTEP_CAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ENABLE  = 3'd4;

  localparam logic [CFG_DATA_W-1:0] STEP_TIME_RST   = 32'd1092;
  localparam logic [CFG_DATA_W-1:0] BANK_LIMIT_RST  = 32'd16384;
  localparam logic [CNT_W-1:0]      SUBSTEP_CAP_RST = 8'd8;
  localparam logic                  DROP_MODE_RST   = 1'b1;
  localparam logic                  STEP_ENABLE_RST = 1'b0;

  localparam logic [LAG_W-1:0] LAG_MAX = {LAG_W{1'b1}};

  typedef struct packed {
    logic drop_mode;
    logic stepping_enabled;
  } fsta_mode_t;

endpackage

// ----- hw/rtl/fsta_if.sv -----
// frame input and step result channel interfaces
interface fsta_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsta_pkg::FRAME_W-1:0]  frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink (input valid, input frame_time, output ready);
endinterface

interface fsta_out_if;
  logic                             valid;
  logic                             ready;
  logic [fsta_pkg::CNT_W-1:0]       substep_count;
  logic [fsta_pkg::OUT_W-1:0]       banked_left;
  logic [fsta_pkg::OUT_W-1:0]       dropped_now;
  logic [fsta_pkg::LAG_W-1:0]       lag_total;
  logic [fsta_pkg::STEP_SUM_W-1:0]  step_total;

  modport source (output valid, output substep_count, output banked_left,
                  output dropped_now, output lag_total, output step_total,
                  input ready);
  modport sink (input valid, input substep_count, input banked_left,
                input dropped_now, input lag_total, input step_total,
                output ready);
endinterface

// ----- hw/rtl/fixed_step_time_accumulator.sv -----
// top level of the fixed step time accumulator
//
//   channel   dir  handshake          beat contents
//   in_ch     in   valid / ready      frame_time
//   out_ch    out  valid / ready      substep_count, banked_left, dropped_now,
//                                     lag_total, step_total
//   cfg_*     in   cfg_we             cfg_idx, cfg_wdata
//
// a frame goes straight to the result with stepping disabled, otherwise it passes
// clamp and substeps, plus a remainder pass when the cap drops time down to the remainder
// (the shared subtract unit takes one step or one remainder bit per cycle)
// in_ch.ready is high only while the sequencer is idle; a finished result
// sits in the output register, and the next frame is taken while it waits
// synchronous active-low reset clears the banked time, lag and step totals
`include "fixed_step_time_accumulator_macros.svh"

module fixed_step_time_accumulator #(
  parameter int TIME_BITS = 32,
  parameter int CAP_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fsta_in_if.sink                         in_ch,
  fsta_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [fsta_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fsta_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIME_BITS-1:0]  step_time;
  logic [TIME_BITS-1:0]  bank_limit;
  logic [CAP_BITS-1:0]   substep_cap;
  fsta_pkg::fsta_mode_t  mode;

  fsta_cfg #(
    .TIME_BITS (TIME_BITS),
    .CAP_BITS  (CAP_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .step_time   (step_time),
    .bank_limit  (bank_limit),
    .substep_cap (substep_cap),
    .mode        (mode)
  );

  fsta_core #(
    .TIME_BITS (TIME_BITS),
    .CAP_BITS  (CAP_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .step_time   (step_time),
    .bank_limit  (bank_limit),
    .substep_cap (substep_cap),
    .mode        (mode)
  );

  // an accepted frame leaves the sequencer busy in the following cycle
  `FSTA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // ready only drops because a frame was taken
  `FSTA_ASSERT_NOW(a_ready_drop_on_accept, $fell(in_ch.ready), $past(in_ch.valid))
  // a fresh result leaves the sequencer idle
  `FSTA_ASSERT_NOW(a_idle_on_result, $rose(out_ch.valid), in_ch.ready)

endmodule

// ----- hw/rtl/fsta_sub.sv -----
// shared subtract and compare unit
module fsta_sub #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  // borrow set means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- hw/rtl/fsta_cfg.sv -----
// configuration register file
module fsta_cfg #(
  parameter int TIME_BITS = 32,
  parameter int CAP_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fsta_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fsta_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [TIME_BITS-1:0]            step_time,
  output logic [TIME_BITS-1:0]            bank_limit,
  output logic [CAP_BITS-1:0]             substep_cap,
  output fsta_pkg::fsta_mode_t            mode
);

  logic [TIME_BITS-1:0]  step_time_r;
  logic [TIME_BITS-1:0]  bank_limit_r;
  logic [CAP_BITS-1:0]   substep_cap_r;
  fsta_pkg::fsta_mode_t  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r             <= TIME_BITS'(fsta_pkg::STEP_TIME_RST);
      bank_limit_r            <= TIME_BITS'(fsta_pkg::BANK_LIMIT_RST);
      substep_cap_r           <= CAP_BITS'(fsta_pkg::SUBSTEP_CAP_RST);
      mode_r.drop_mode        <= fsta_pkg::DROP_MODE_RST;
      mode_r.stepping_enabled <= fsta_pkg::STEP_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fsta_pkg::REG_STEP_TIME: begin
          step_time_r <= TIME_BITS'(cfg_wdata);
        end
        fsta_pkg::REG_BANK_LIMIT: begin
          bank_limit_r <= TIME_BITS'(cfg_wdata);
        end
        fsta_pkg::REG_SUBSTEP_CAP: begin
          substep_cap_r <= CAP_BITS'(cfg_wdata[fsta_pkg::CNT_W-1:0]);
        end
        fsta_pkg::REG_DROP_MODE: begin
          mode_r.drop_mode <= cfg_wdata[0];
        end
        fsta_pkg::REG_STEP_ENABLE: begin
          mode_r.stepping_enabled <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign step_time   = step_time_r;
  assign bank_limit  = bank_limit_r;
  assign substep_cap = substep_cap_r;
  assign mode        = mode_r;

endmodule

// ----- hw/rtl/fsta_core.sv -----
// sequencer, datapath and result register of the accumulator
module fsta_core #(
  parameter int TIME_BITS = 32,
  parameter int CAP_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fsta_in_if.sink               in_ch,
  fsta_out_if.source            out_ch,
  input  logic [TIME_BITS-1:0]  step_time,
  input  logic [TIME_BITS-1:0]  bank_limit,
  input  logic [CAP_BITS-1:0]   substep_cap,
  input  fsta_pkg::fsta_mode_t  mode
);

  localparam int W   = TIME_BITS;
  localparam int SW  = TIME_BITS + 1;
  localparam int BCW = $clog2(TIME_BITS);
  localparam int LAW = fsta_pkg::LAG_W + 2;
  localparam int DXW = SW + fsta_pkg::OUT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLAMP = 6'b000010,
    S_STEP  = 6'b000100,
    S_MOD   = 6'b001000,
    S_DRP   = 6'b010000,
    S_FIN   = 6'b100000
  } fsta_state_t;

  fsta_state_t state_r, state_nxt;

  logic [W-1:0]                     banked_r, banked_nxt;
  logic [fsta_pkg::LAG_W-1:0]       lag_r, lag_nxt;
  logic [fsta_pkg::STEP_SUM_W-1:0]  step_sum_r, step_sum_nxt;
  logic [SW-1:0]                    sum_r, sum_nxt;
  logic [W-1:0]                     acc_r, acc_nxt;
  logic [SW-1:0]                    dropped_r, dropped_nxt;
  logic [CAP_BITS-1:0]              count_r, count_nxt;
  logic [W-1:0]                     rem_r, rem_nxt;
  logic [W-1:0]                     mod_sh_r, mod_sh_nxt;
  logic [BCW-1:0]                   bit_cnt_r, bit_cnt_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [fsta_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;
  logic [fsta_pkg::OUT_W-1:0]       out_banked_r, out_banked_nxt;
  logic [fsta_pkg::OUT_W-1:0]       out_dropped_r, out_dropped_nxt;
  logic [fsta_pkg::LAG_W-1:0]       out_lag_r, out_lag_nxt;
  logic [fsta_pkg::STEP_SUM_W-1:0]  out_steps_r, out_steps_nxt;

  logic [SW-1:0]                    sub_a, sub_b, sub_diff;
  logic                             sub_borrow;
  logic [LAW-1:0]                   lag_add;
  logic [fsta_pkg::LAG_W-1:0]       lag_new;
  logic [DXW-1:0]                   drop_ext;
  logic [fsta_pkg::OUT_W-1:0]       drop_sat;
  logic [fsta_pkg::STEP_SUM_W-1:0]  step_sum_new;

  fsta_sub #(.WIDTH(SW)) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // end-of-frame bookkeeping
  always_comb begin
    lag_add      = LAW'(lag_r) + LAW'(dropped_r);
    lag_new      = (lag_add > LAW'(fsta_pkg::LAG_MAX)) ? fsta_pkg::LAG_MAX
                                                       : lag_add[fsta_pkg::LAG_W-1:0];
    drop_ext     = DXW'(dropped_r);
    drop_sat     = (|drop_ext[DXW-1:fsta_pkg::OUT_W]) ? {fsta_pkg::OUT_W{1'b1}}
                                                      : drop_ext[fsta_pkg::OUT_W-1:0];
    step_sum_new = step_sum_r + fsta_pkg::STEP_SUM_W'(count_r);
  end

  always_comb begin
    state_nxt       = state_r;
    banked_nxt      = banked_r;
    lag_nxt         = lag_r;
    step_sum_nxt    = step_sum_r;
    sum_nxt         = sum_r;
    acc_nxt         = acc_r;
    dropped_nxt     = dropped_r;
    count_nxt       = count_r;
    rem_nxt         = rem_r;
    mod_sh_nxt      = mod_sh_r;
    bit_cnt_nxt     = bit_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_count_nxt   = out_count_r;
    out_banked_nxt  = out_banked_r;
    out_dropped_nxt = out_dropped_r;
    out_lag_nxt     = out_lag_r;
    out_steps_nxt   = out_steps_r;
    sub_a           = '0;
    sub_b           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          acc_nxt     = banked_r;
          count_nxt   = '0;
          dropped_nxt = '0;
          if (mode.stepping_enabled) begin
            sum_nxt   = SW'(banked_r) + SW'(W'(in_ch.frame_time));
            state_nxt = S_CLAMP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CLAMP: begin
        sub_a = sum_r;
        sub_b = SW'(bank_limit);
        if (!sub_borrow) begin
          acc_nxt     = bank_limit;
          dropped_nxt = sub_diff;
        end else begin
          acc_nxt = sum_r[W-1:0];
        end
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // one fixed step per cycle while a full step is banked and the cap is not reached
        sub_a = SW'(acc_r);
        sub_b = SW'(step_time);
        if (sub_borrow) begin
          state_nxt = S_FIN;
        end else if (count_r == substep_cap) begin
          if (!mode.drop_mode) begin
            state_nxt = S_FIN;
          end else begin
            rem_nxt     = '0;
            mod_sh_nxt  = acc_r;
            bit_cnt_nxt = BCW'(W - 1);
            state_nxt   = (step_time == '0) ? S_DRP : S_MOD;
          end
        end else begin
          acc_nxt   = sub_diff[W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      S_MOD: begin
        // restoring remainder, one bit per cycle
        sub_a      = {rem_r, mod_sh_r[W-1]};
        sub_b      = SW'(step_time);
        rem_nxt    = sub_borrow ? sub_a[W-1:0] : sub_diff[W-1:0];
        mod_sh_nxt = {mod_sh_r[W-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          state_nxt = S_DRP;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end
      S_DRP: begin
        sub_a       = SW'(acc_r);
        sub_b       = SW'(rem_r);
        dropped_nxt = dropped_r + sub_diff;
        acc_nxt     = rem_r;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          banked_nxt      = acc_r;
          lag_nxt         = lag_new;
          step_sum_nxt    = step_sum_new;
          out_valid_nxt   = 1'b1;
          out_count_nxt   = fsta_pkg::CNT_W'(count_r);
          out_banked_nxt  = fsta_pkg::OUT_W'(acc_r);
          out_dropped_nxt = drop_sat;
          out_lag_nxt     = lag_new;
          out_steps_nxt   = step_sum_new;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      banked_r    <= '0;
      lag_r       <= '0;
      step_sum_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      banked_r    <= banked_nxt;
      lag_r       <= lag_nxt;
      step_sum_r  <= step_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r         <= sum_nxt;
    acc_r         <= acc_nxt;
    dropped_r     <= dropped_nxt;
    count_r       <= count_nxt;
    rem_r         <= rem_nxt;
    mod_sh_r      <= mod_sh_nxt;
    bit_cnt_r     <= bit_cnt_nxt;
    out_count_r   <= out_count_nxt;
    out_banked_r  <= out_banked_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_lag_r     <= out_lag_nxt;
    out_steps_r   <= out_steps_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.substep_count = out_count_r;
  assign out_ch.banked_left   = out_banked_r;
  assign out_ch.dropped_now   = out_dropped_r;
  assign out_ch.lag_total     = out_lag_r;
  assign out_ch.step_total    = out_steps_r;

endmodule

// ----- tb/tb.sv -----
// testbench for the fixed step time accumulator: random frames checked against a predictor
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 300;
  localparam int RANDOM_FRAMES  = 650;
  localparam int LAG_FILL       = 20;

  typedef struct packed {
    logic [fsta_pkg::CNT_W-1:0]      count;
    logic [fsta_pkg::OUT_W-1:0]      banked;
    logic [fsta_pkg::OUT_W-1:0]      dropped;
    logic [fsta_pkg::LAG_W-1:0]      lag;
    logic [fsta_pkg::STEP_SUM_W-1:0] steps;
  } step_result_t;

  class step_scoreboard;
    logic [fsta_pkg::FRAME_W-1:0]    step_len = fsta_pkg::STEP_TIME_RST;
    logic [fsta_pkg::FRAME_W-1:0]    limit    = fsta_pkg::BANK_LIMIT_RST;
    logic [fsta_pkg::CNT_W-1:0]      cap      = fsta_pkg::SUBSTEP_CAP_RST;
    logic                            keep_rem = fsta_pkg::DROP_MODE_RST;
    logic                            enabled  = fsta_pkg::STEP_ENABLE_RST;
    logic [fsta_pkg::FRAME_W-1:0]    bank     = '0;
    logic [fsta_pkg::LAG_W-1:0]      lag      = '0;
    logic [fsta_pkg::STEP_SUM_W-1:0] steps    = '0;
    step_result_t                    expected_q[$];
    int                              errors   = 0;

    function void set_reg(logic [fsta_pkg::CFG_IDX_W-1:0] idx,
                          logic [fsta_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        fsta_pkg::REG_STEP_TIME:   step_len = val;
        fsta_pkg::REG_BANK_LIMIT:  limit = val;
        fsta_pkg::REG_SUBSTEP_CAP: cap = val[fsta_pkg::CNT_W-1:0];
        fsta_pkg::REG_DROP_MODE:   keep_rem = val[0];
        fsta_pkg::REG_STEP_ENABLE: enabled = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // expected result of one accepted frame
    function void note_frame(logic [fsta_pkg::FRAME_W-1:0] ft);
      logic [63:0] sum, acc, dropped, kept, whole, count, st, lim, cp;
      step_result_t r;
      count = '0;
      dropped = '0;
      st = {32'b0, step_len};
      lim = {32'b0, limit};
      cp = {56'b0, cap};
      if (enabled) begin
        // full-width sum, no wrap before the clamp
        sum = {32'b0, bank} + {32'b0, ft};
        acc = (sum < lim) ? sum : lim;
        dropped = sum - acc;
        if (st == 0) begin
          count = cp;
        end else begin
          whole = acc / st;
          count = (whole < cp) ? whole : cp;
          acc = acc - count * st;
        end
        if (count >= cp && acc >= st) begin
          if (!keep_rem) kept = acc;
          else if (st != 0) kept = acc % st;
          else kept = '0;
          dropped = dropped + (acc - kept);
          acc = kept;
        end
        bank = acc[fsta_pkg::FRAME_W-1:0];
        steps = steps + count[fsta_pkg::STEP_SUM_W-1:0];
        if (dropped >= ({16'b0, fsta_pkg::LAG_MAX} - {16'b0, lag})) lag = fsta_pkg::LAG_MAX;
        else lag = lag + dropped[fsta_pkg::LAG_W-1:0];
      end
      r.count = count[fsta_pkg::CNT_W-1:0];
      r.banked = bank;
      r.dropped = (dropped > 64'hFFFF_FFFF) ? '1 : dropped[fsta_pkg::OUT_W-1:0];
      r.lag = lag;
      r.steps = steps;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(step_result_t got);
      step_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      cmp_field("substep_count", 64'(exp_r.count), 64'(got.count));
      cmp_field("banked_left", 64'(exp_r.banked), 64'(got.banked));
      cmp_field("dropped_now", 64'(exp_r.dropped), 64'(got.dropped));
      cmp_field("lag_total", 64'(exp_r.lag), 64'(got.lag));
      cmp_field("step_total", 64'(exp_r.steps), 64'(got.steps));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fsta_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fsta_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              no_gaps;
  int                              quiet;
  step_scoreboard                  sb;

  fsta_in_if  in_ch ();
  fsta_out_if out_ch ();

  fixed_step_time_accumulator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog on cycles without any beat
  initial quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [fsta_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsta_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] st, input logic [31:0] lim, input logic [7:0] cp,
                         input logic keep, input logic en);
    write_reg(fsta_pkg::REG_STEP_TIME, st);
    write_reg(fsta_pkg::REG_BANK_LIMIT, lim);
    write_reg(fsta_pkg::REG_SUBSTEP_CAP, {24'b0, cp});
    write_reg(fsta_pkg::REG_DROP_MODE, {31'b0, keep});
    write_reg(fsta_pkg::REG_STEP_ENABLE, {31'b0, en});
  endtask

  task automatic send_frame(input logic [fsta_pkg::FRAME_W-1:0] ft);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.frame_time <= ft;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_frame(ft);
  endtask

  // drop valid and wait for every result, leaving the block idle
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_frame(logic [31:0] st);
    logic [63:0] multiple;
    multiple = 64'(st) * $urandom_range(0, 12);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return '0;
      2: return multiple[31:0];
      3: return multiple[31:0] + $urandom_range(0, 3);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, st);
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [31:0] st, lim;
    logic [7:0]  cp;
    logic [63:0] span;
    case ($urandom_range(0, 4))
      0: st = $urandom_range(1, 16);
      1: st = $urandom_range(17, 4096);
      2: st = $urandom_range(4097, 1 << 20);
      3: st = $urandom | 32'h1;
      default: st = 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
    span = 64'(st) * $urandom_range(0, 20);
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      2: lim = $urandom;
      3: lim = 32'hFFFF_FFFF;
      default: lim = $urandom_range(0, 1 << 16);
    endcase
    case ($urandom_range(0, 9))
      0: cp = '0;
      1: cp = 8'hFF;
      2, 3, 4, 5: cp = 8'($urandom_range(1, 4));
      default: cp = 8'($urandom_range(5, 32));
    endcase
    set_all(st, lim, cp, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n) send_frame(pick_frame(st));
    settle();
  endtask

  initial begin : result_sink
    int stall;
    step_result_t got;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.count = out_ch.substep_count;
      got.banked = out_ch.banked_left;
      got.dropped = out_ch.dropped_now;
      got.lag = out_ch.lag_total;
      got.steps = out_ch.step_total;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int done_frames;
    int n;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.frame_time = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stepping off after reset: state passes through unchanged
    send_frame(32'h0);
    send_frame(32'hFFFF_FFFF);
    settle();

    // reset settings with stepping on, including bank overflow past the limit
    write_reg(fsta_pkg::REG_STEP_ENABLE, 32'd1);
    send_frame(32'h0);
    send_frame(32'd1091);
    send_frame(32'd1);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd16384);
    send_frame(32'd8735);
    settle();

    // no substeps allowed
    write_reg(fsta_pkg::REG_SUBSTEP_CAP, 32'd0);
    send_frame(32'd2000);
    send_frame(32'd500);
    settle();

    // backlog kept at the cap
    write_reg(fsta_pkg::REG_SUBSTEP_CAP, 32'd2);
    write_reg(fsta_pkg::REG_DROP_MODE, 32'd0);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd5000);
    settle();

    // zero step length, both drop modes
    write_reg(fsta_pkg::REG_STEP_TIME, 32'd0);
    send_frame(32'd100);
    settle();
    write_reg(fsta_pkg::REG_DROP_MODE, 32'd1);
    send_frame(32'd7);
    send_frame(32'd100);
    settle();

    // widest settings
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd1);
    settle();
    set_all(32'd1, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd300);
    settle();

    done_frames = 0;
    while (done_frames < RANDOM_FRAMES) begin
      n = $urandom_range(15, 40);
      random_phase(n);
      done_frames += n;
    end

    // heavy drops with nothing banked, back to back
    set_all(32'hFFFF_FFFF, 32'h0, 8'h0, 1'b1, 1'b1);
    no_gaps = 1'b1;
    repeat (LAG_FILL) send_frame(32'hFFFF_FFFF);
    no_gaps = 1'b0;
    repeat (4) send_frame($urandom);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- fixed_step_time_accumulator.f -----
+incdir+hw/rtl
hw/rtl/fsta_pkg.sv
hw/rtl/fsta_if.sv
hw/rtl/fsta_sub.sv
hw/rtl/fsta_cfg.sv
hw/rtl/fsta_core.sv
hw/rtl/fixed_step_time_accumulator.sv
tb/tb.sv
